### sv/jmch_pkg.sv
// Package for the gift-wrapping convex hull block: constants, payload types and states.
`default_nettype none
package jmch_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_BITS  = 16;
  localparam int MAX_RESULTS = 64;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int NOUT_W = $clog2(MAX_RESULTS);
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int PT_W   = 2 * COORD_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;
  } point_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         last_vertex;
    logic                         too_few_points;
  } result_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VTX,
    S_RD,
    S_CHK,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_DEC,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

### sv/jmch_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read data that holds between reads.
`default_nettype none
module jmch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/jarvis_march_convex_hull.sv
// Gift-wrapping convex hull: point store, pivot tracking and a sequenced cross-product unit.
// Points load one per cycle while busy is low. After the last point, each hull vertex scans every
// stored point: one equal to the current vertex is skipped after its read and compare, any other
// goes through one shared 17x17 multiplier run four times and then the decision step.
// Results appear one per strobe and cannot be stalled; fewer than three points give one error.
// Synchronous reset clears the sequencer, point count and pivot; store contents stay undefined.
`default_nettype none
module jarvis_march_convex_hull (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire jmch_pkg::point_in_t point,
  output logic                     busy,
  output logic                     result_valid,
  output jmch_pkg::result_t        result
);
  import jmch_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]  point_count;
  logic [IDX_W-1:0]  j;
  logic [NOUT_W-1:0] nout;
  pt_t               pivot, pivot_next, cur, best, p_in, q;
  logic              best_valid;

  logic signed [DIFF_W-1:0] dbx, dby, dqx, dqy;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, lprod, rprod;
  logic        [PROD_W-1:0] dacc, dist_q, best_dist;

  logic             accept, store_pt, start_wrap, few;
  logic [CNT_W-1:0] cnt_after;
  logic             at_limit, last_j, same_q, term, take;
  logic             ram_we, ram_re, res_load;
  result_t          res_value;
  logic [PT_W-1:0]  rdata;

  jmch_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (point_count[IDX_W-1:0]),
    .wdata (p_in),
    .re    (ram_re),
    .raddr (j),
    .rdata (rdata)
  );

  assign p_in = '{x: point.point_x, y: point.point_y};
  assign q    = pt_t'(rdata);

  assign accept     = start && !busy;
  assign store_pt   = accept && (point_count < CNT_W'(MAX_POINTS));
  assign cnt_after  = store_pt ? point_count + CNT_W'(1) : point_count;
  assign few        = accept && point.last_point && (cnt_after < CNT_W'(3));
  assign start_wrap = accept && point.last_point && !few;

  always_comb begin
    pivot_next = pivot;
    if (store_pt && ((point_count == '0) || (p_in.x < pivot.x) ||
                     ((p_in.x == pivot.x) && (p_in.y < pivot.y)))) begin
      pivot_next = p_in;
    end
  end

  assign at_limit = (nout == NOUT_W'(MAX_RESULTS - 1));
  assign last_j   = (CNT_W'(j) == point_count - CNT_W'(1));
  assign same_q   = (q == cur);
  assign term     = !best_valid || (best == pivot);
  assign take     = !best_valid || (lprod < rprod) ||
                    ((lprod == rprod) && (dist_q > best_dist));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start_wrap) state_next = S_VTX;
      S_VTX:  state_next = at_limit ? S_IDLE : S_RD;
      S_RD:   state_next = S_CHK;
      S_CHK: begin
        if (same_q) begin
          state_next = last_j ? S_EMIT : S_RD;
        end else begin
          state_next = S_M0;
        end
      end
      S_M0:   state_next = S_M1;
      S_M1:   state_next = S_M2;
      S_M2:   state_next = S_M3;
      S_M3:   state_next = S_M4;
      S_M4:   state_next = S_DEC;
      S_DEC:  state_next = last_j ? S_EMIT : S_RD;
      S_EMIT: state_next = term ? S_IDLE : S_VTX;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != S_IDLE);
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    mul_a     = dbx;
    mul_b     = dqy;
    res_load  = 1'b0;
    res_value = '0;
    unique case (state)
      S_IDLE: begin
        ram_we = store_pt;
        if (few) begin
          res_load                 = 1'b1;
          res_value.last_vertex    = 1'b1;
          res_value.too_few_points = 1'b1;
        end
      end
      S_VTX: begin
        if (at_limit) begin
          res_load              = 1'b1;
          res_value.vertex_x    = cur.x;
          res_value.vertex_y    = cur.y;
          res_value.last_vertex = 1'b1;
        end
      end
      S_RD: ram_re = 1'b1;
      S_M1: begin
        mul_a = dqx;
        mul_b = dby;
      end
      S_M2: begin
        mul_a = dqx;
        mul_b = dqx;
      end
      S_M3: begin
        mul_a = dqy;
        mul_b = dqy;
      end
      S_EMIT: begin
        res_load              = 1'b1;
        res_value.vertex_x    = cur.x;
        res_value.vertex_y    = cur.y;
        res_value.last_vertex = term;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (res_load) begin
      result <= res_value;
    end
    if (rst) begin
      state        <= S_IDLE;
      point_count  <= '0;
      pivot        <= '0;
      cur          <= '0;
      best         <= '0;
      best_valid   <= 1'b0;
      result_valid <= 1'b0;
      j            <= '0;
      nout         <= '0;
    end else begin
      state        <= state_next;
      result_valid <= res_load;
      unique case (state)
        S_IDLE: begin
          pivot       <= pivot_next;
          point_count <= few ? '0 : cnt_after;
          if (start_wrap) begin
            cur  <= pivot_next;
            nout <= '0;
          end
        end
        S_VTX: begin
          if (at_limit) begin
            point_count <= '0;
          end else begin
            j          <= '0;
            best_valid <= 1'b0;
          end
        end
        S_CHK: begin
          dbx <= DIFF_W'(best.x) - DIFF_W'(cur.x);
          dby <= DIFF_W'(best.y) - DIFF_W'(cur.y);
          dqx <= DIFF_W'(q.x) - DIFF_W'(cur.x);
          dqy <= DIFF_W'(q.y) - DIFF_W'(cur.y);
          if (same_q && !last_j) begin
            j <= j + IDX_W'(1);
          end
        end
        S_M1: lprod <= prod;
        S_M2: rprod <= prod;
        S_M3: dacc  <= PROD_W'(prod);
        S_M4: dist_q <= dacc + PROD_W'(prod);
        S_DEC: begin
          if (take) begin
            best       <= q;
            best_dist  <= dist_q;
            best_valid <= 1'b1;
          end
          if (!last_j) begin
            j <= j + IDX_W'(1);
          end
        end
        S_EMIT: begin
          if (term) begin
            point_count <= '0;
          end else begin
            cur  <= best;
            nout <= nout + NOUT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_few_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.too_few_points |-> result.last_vertex)
    else $error("Error result without the last-vertex flag.");

  a_end_clears_set: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_vertex |-> point_count == '0)
    else $error("Point set not cleared at the end of a run.");

  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_vertex |-> busy)
    else $error("Walk stopped after a vertex that was not the last.");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> CNT_W'(j) < point_count)
    else $error("Scan read beyond the stored points.");

endmodule
`default_nettype wire
